FILE: hw/rtl/card_deck_shuffle_draw_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// card deck engine assertion macros
// shared concurrent assertion forms, sampled on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef CARD_DECK_SHUFFLE_DRAW_ENGINE_UNIT_MACROS_SVH
`define CARD_DECK_SHUFFLE_DRAW_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define CDSE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/cdse_pkg.sv
// ----------------------------------------------------------------------------
// cdse_pkg
// shared constants, types and the ordered-deck function of the card engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdse_pkg;

   // defaults for the top-level parameters
   localparam int DECK_SIZE_DEF    = 52;
   localparam int RANDOM_WIDTH_DEF = 32;

   // fixed field widths
   localparam int SLOT_W = 6;
   localparam int RAND_W = 32;
   localparam int CMD_W  = 2;
   localparam int RANK_W = 4;
   localparam int SUIT_W = 2;

   localparam int RANKS_PER_SUIT = 13;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SHUFFLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd3;

   // one deck slot: card plus empty mark
   typedef struct packed {
      logic              empty;
      logic [SUIT_W-1:0] suit;
      logic [RANK_W-1:0] rank;
   } deck_entry_type;

   // access request from the sequencer to the deck memory
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      deck_entry_type    wr_data;
   } ram_req_type;

   // card held by a slot of the ordered deck, suit-major
   function automatic deck_entry_type ordered_card(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W-1:0] r;
      logic [2:0]        q;
      deck_entry_type    e;
      r = idx;
      q = '0;
      for (int k = 0; k < 4; k++) begin
         if (r >= SLOT_W'(RANKS_PER_SUIT)) begin
            r = r - SLOT_W'(RANKS_PER_SUIT);
            q = q + 3'd1;
         end
      end
      e.empty = 1'b0;
      e.suit  = q[SUIT_W-1:0];
      e.rank  = r[RANK_W-1:0];
      return e;
   endfunction

endpackage

FILE: hw/rtl/cdse_if.sv
// ----------------------------------------------------------------------------
// cdse channel interfaces
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// command channel
interface cdse_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [cdse_pkg::CMD_W-1:0]              command;
   logic [cdse_pkg::RAND_W-1:0]             random_word;
   logic [cdse_pkg::SLOT_W-1:0]             slot_index;

   modport source (output valid, command, random_word, slot_index, input ready);
   modport sink   (input valid, command, random_word, slot_index, output ready);
endinterface

// result channel
interface cdse_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [cdse_pkg::RANK_W-1:0]             card_rank;
   logic [cdse_pkg::SUIT_W-1:0]             card_suit;
   logic                                    card_valid;
   logic                                    shuffle_done;

   modport source (output valid, card_rank, card_suit, card_valid, shuffle_done,
                   input ready);
   modport sink   (input valid, card_rank, card_suit, card_valid, shuffle_done,
                   output ready);
endinterface

FILE: hw/rtl/cdse_mod_serial.sv
// ----------------------------------------------------------------------------
// cdse_mod_serial
// bit-serial restoring remainder: one dividend bit shifted in per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdse_mod_serial #(
   parameter int DATA_W = cdse_pkg::RAND_W,
   parameter int IDX_W  = cdse_pkg::SLOT_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [IDX_W:0]    divisor,
   output logic              done,
   output logic [IDX_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic [DATA_W-1:0] sh_ff, sh_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W:0]    div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [IDX_W:0]    trial;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff, sh_ff[DATA_W-1]};
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(DATA_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = {sh_ff[DATA_W-2:0], 1'b0};
         if (trial >= div_ff) begin
            rem_in = IDX_W'(trial - div_ff);
         end else begin
            rem_in = trial[IDX_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/cdse_deck_ram.sv
// ----------------------------------------------------------------------------
// cdse_deck_ram
// deck slot memory, one read and one write port, registered read data;
// per-slot written bits make unwritten slots read as the ordered deck
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdse_deck_ram #(
   parameter int DECK_SIZE = cdse_pkg::DECK_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cdse_pkg::ram_req_type    req,
   output cdse_pkg::deck_entry_type rd_data
);

   localparam int IDX_W = $clog2(DECK_SIZE);

   cdse_pkg::deck_entry_type mem [DECK_SIZE];
   cdse_pkg::deck_entry_type mem_q_ff;
   logic [DECK_SIZE-1:0]     written_ff, written_in;
   logic                     rd_written_ff, rd_written_in;
   logic [cdse_pkg::SLOT_W-1:0] rd_addr_ff;

   // written bits: clear drops all, a write sets its slot
   always_comb begin
      written_in    = written_ff;
      rd_written_in = rd_written_ff;
      if (req.clear) begin
         written_in = '0;
      end else if (req.wr_en) begin
         written_in[req.wr_addr[IDX_W-1:0]] = 1'b1;
      end
      if (req.rd_en) begin
         rd_written_in = written_ff[req.rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         rd_written_ff <= rd_written_in;
      end
   end

   // storage array
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         mem_q_ff   <= mem[req.rd_addr[IDX_W-1:0]];
         rd_addr_ff <= req.rd_addr;
      end
   end

   assign rd_data = rd_written_ff ? mem_q_ff : cdse_pkg::ordered_card(rd_addr_ff);

endmodule

FILE: hw/rtl/card_deck_shuffle_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// card_deck_shuffle_draw_engine_unit
// Deck of DECK_SIZE card slots with init, Fisher-Yates shuffle step, draw and
// discard commands; each command beat returns one result beat. Commands run
// one at a time. A shuffle step waits on the bit-serial remainder unit (one
// random bit per cycle), then makes four deck memory accesses for the swap. A
// draw walks the deck one slot per cycle through the memory read port until it
// finds a live slot or reaches the end of the deck. A new command is taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "card_deck_shuffle_draw_engine_unit_macros.svh"

module card_deck_shuffle_draw_engine_unit #(
   parameter int DECK_SIZE    = cdse_pkg::DECK_SIZE_DEF,
   parameter int RANDOM_WIDTH = cdse_pkg::RANDOM_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cdse_req_if.sink    req_bus,
   cdse_rsp_if.source  rsp_bus
);

   localparam int IDX_W  = $clog2(DECK_SIZE);
   localparam int CNT_W  = $clog2(DECK_SIZE + 1);
   localparam int RW_EFF = (RANDOM_WIDTH < cdse_pkg::RAND_W) ? RANDOM_WIDTH
                                                             : cdse_pkg::RAND_W;
   localparam int SW     = cdse_pkg::SLOT_W;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_DIV     = 10'b0000000010,
      ST_RD_A    = 10'b0000000100,
      ST_RD_B    = 10'b0000001000,
      ST_WR_A    = 10'b0000010000,
      ST_WR_B    = 10'b0000100000,
      ST_SCAN    = 10'b0001000000,
      ST_DISC_RD = 10'b0010000000,
      ST_DISC_WR = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic [IDX_W-1:0]             work_pos_ff, work_pos_in;
   logic [IDX_W-1:0]             pos_eff;
   logic [SW-1:0]                slot_ff, slot_in;
   logic [CNT_W-1:0]             sc_ff, sc_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]             chk_addr_ff, chk_addr_in;
   cdse_pkg::deck_entry_type     hold_ff, hold_in;
   logic [cdse_pkg::RANK_W-1:0]  res_rank_ff, res_rank_in;
   logic [cdse_pkg::SUIT_W-1:0]  res_suit_ff, res_suit_in;
   logic                         res_valid_ff, res_valid_in;
   logic                         res_done_ff, res_done_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cdse_pkg::RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic [cdse_pkg::SUIT_W-1:0]  rsp_suit_ff, rsp_suit_in;
   logic                         rsp_card_ff, rsp_card_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic                         accept;
   logic                         out_load;
   logic                         mod_start;
   logic                         mod_done;
   logic [IDX_W-1:0]             mod_rem;
   logic [IDX_W:0]               mod_divisor;
   cdse_pkg::ram_req_type        ram_req;
   cdse_pkg::deck_entry_type     ram_rd_data;

   assign accept = req_bus.valid && (state_ff == ST_IDLE);

   // position used by a shuffle step, zero or out-of-range folds to the top slot
   assign pos_eff = ((pos_ff == '0) || (pos_ff > IDX_W'(DECK_SIZE - 1)))
                    ? IDX_W'(DECK_SIZE - 1) : pos_ff;
   assign mod_divisor = {1'b0, pos_eff} + (IDX_W + 1)'(1);

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      work_pos_in  = work_pos_ff;
      slot_in      = slot_ff;
      sc_in        = sc_ff;
      chk_vld_in   = chk_vld_ff;
      chk_addr_in  = chk_addr_ff;
      hold_in      = hold_ff;
      res_rank_in  = res_rank_ff;
      res_suit_in  = res_suit_ff;
      res_valid_in = res_valid_ff;
      res_done_in  = res_done_ff;
      mod_start    = 1'b0;
      out_load     = 1'b0;
      ram_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_rank_in  = '0;
               res_suit_in  = '0;
               res_valid_in = 1'b0;
               res_done_in  = 1'b0;
               case (req_bus.command)
                  cdse_pkg::CMD_INIT: begin
                     ram_req.clear = 1'b1;
                     state_in      = ST_OUT;
                  end
                  cdse_pkg::CMD_SHUFFLE: begin
                     mod_start   = 1'b1;
                     work_pos_in = pos_eff;
                     if (pos_eff == IDX_W'(1)) begin
                        res_done_in = 1'b1;
                        pos_in      = IDX_W'(DECK_SIZE - 1);
                     end else begin
                        pos_in = pos_eff - IDX_W'(1);
                     end
                     state_in = ST_DIV;
                  end
                  cdse_pkg::CMD_DRAW: begin
                     sc_in      = '0;
                     chk_vld_in = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  cdse_pkg::CMD_DISCARD: begin
                     slot_in = req_bus.slot_index;
                     if (req_bus.slot_index <= SW'(DECK_SIZE - 1)) begin
                        state_in = ST_DISC_RD;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               state_in = ST_RD_A;
            end
         end
         // swap: read both slots, then write each with the other
         ST_RD_A: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = SW'(work_pos_ff);
            state_in        = ST_RD_B;
         end
         ST_RD_B: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = SW'(mod_rem);
            hold_in         = ram_rd_data;
            state_in        = ST_WR_A;
         end
         ST_WR_A: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = SW'(work_pos_ff);
            ram_req.wr_data = ram_rd_data;
            state_in        = ST_WR_B;
         end
         ST_WR_B: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = SW'(mod_rem);
            ram_req.wr_data = hold_ff;
            state_in        = ST_OUT;
         end
         // draw: one slot read per cycle, check the one read last cycle
         ST_SCAN: begin
            chk_vld_in = 1'b0;
            if (chk_vld_ff && !ram_rd_data.empty) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = SW'(chk_addr_ff);
               ram_req.wr_data = '{empty: 1'b1, suit: ram_rd_data.suit,
                                   rank: ram_rd_data.rank};
               res_rank_in     = ram_rd_data.rank;
               res_suit_in     = ram_rd_data.suit;
               res_valid_in    = 1'b1;
               state_in        = ST_OUT;
            end else if (sc_ff < CNT_W'(DECK_SIZE)) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = SW'(sc_ff);
               chk_addr_in     = IDX_W'(sc_ff);
               chk_vld_in      = 1'b1;
               sc_in           = sc_ff + CNT_W'(1);
            end else begin
               state_in = ST_OUT;
            end
         end
         // discard: read-modify-write of the empty mark
         ST_DISC_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = slot_ff;
            state_in        = ST_DISC_WR;
         end
         ST_DISC_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = slot_ff;
            ram_req.wr_data = '{empty: 1'b1, suit: ram_rd_data.suit,
                                rank: ram_rd_data.rank};
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register for the result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_suit_in  = rsp_suit_ff;
      rsp_card_in  = rsp_card_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_rank_in  = res_rank_ff;
         rsp_suit_in  = res_suit_ff;
         rsp_card_in  = res_valid_ff;
         rsp_done_in  = res_done_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= IDX_W'(DECK_SIZE - 1);
         chk_vld_ff   <= 1'b0;
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         chk_vld_ff   <= chk_vld_in;
         sc_ff        <= sc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_pos_ff  <= work_pos_in;
      slot_ff      <= slot_in;
      chk_addr_ff  <= chk_addr_in;
      hold_ff      <= hold_in;
      res_rank_ff  <= res_rank_in;
      res_suit_ff  <= res_suit_in;
      res_valid_ff <= res_valid_in;
      res_done_ff  <= res_done_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_suit_ff  <= rsp_suit_in;
      rsp_card_ff  <= rsp_card_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // swap index: random word mod (position + 1)
   cdse_mod_serial #(
      .DATA_W (RW_EFF),
      .IDX_W  (IDX_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_bus.random_word[RW_EFF-1:0]),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // deck slot memory
   cdse_deck_ram #(
      .DECK_SIZE (DECK_SIZE)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.card_rank    = rsp_rank_ff;
   assign rsp_bus.card_suit    = rsp_suit_ff;
   assign rsp_bus.card_valid   = rsp_card_ff;
   assign rsp_bus.shuffle_done = rsp_done_ff;

   // checks
   `CDSE_ASSERT_IMPL(a_mod_done_in_div, mod_done, state_ff == ST_DIV, "remainder outside divide wait")
   `CDSE_ASSERT_IMPL(a_no_overwrite, out_load, !rsp_valid_ff || rsp_bus.ready, "result beat overwritten")
   `CDSE_ASSERT_IMPL(a_ram_one_op, ram_req.wr_en, !ram_req.rd_en && !ram_req.clear, "memory port conflict")
   `CDSE_ASSERT_IMPL(a_pos_live, 1'b1, pos_ff != '0, "shuffle position reached zero")
   `CDSE_ASSERT_NEXT(a_shuffle_to_div, accept && (req_bus.command == cdse_pkg::CMD_SHUFFLE), state_ff == ST_DIV, "shuffle did not start divide")

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the card deck engine. A predictor tracks the deck,
// the empty marks and the shuffle position, and works out one expected result
// per accepted command. A checker compares each result beat with the oldest
// expectation. Stimulus is a directed set, a long receiver hold-off with
// queued draws, and random games (shuffle passes followed by draws, discards,
// further shuffles and inits). Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int DECK          = cdse_pkg::DECK_SIZE_DEF;
   localparam int ITEM_GOAL     = 1550;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 2 * (DECK + 8);
   localparam int MAX_REPORTS   = 10;

   // one result beat as the predictor sees it
   typedef struct packed {
      logic [cdse_pkg::RANK_W-1:0] rank;
      logic [cdse_pkg::SUIT_W-1:0] suit;
      logic                        valid;
      logic                        done;
   } card_outcome_type;

   logic clock;
   logic reset;

   cdse_req_if req_bus ();
   cdse_rsp_if rsp_bus ();

   card_deck_shuffle_draw_engine_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predictor state
   cdse_pkg::deck_entry_type    deck_model [DECK];
   logic [cdse_pkg::SLOT_W-1:0] shuffle_pos_model;
   card_outcome_type            pending_outcomes [$];
   card_outcome_type            last_outcome;

   int unsigned beats_sent;
   int unsigned mismatch_count;
   int unsigned rsp_hold_cycles;
   bit          idle_enable;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAIL card_deck_shuffle_draw_engine_unit");
      $finish;
   end

   // ordered deck, suit-major, all marks clear
   function automatic void load_ordered_deck();
      for (int i = 0; i < DECK; i++) begin
         deck_model[i].empty = 1'b0;
         deck_model[i].rank  = cdse_pkg::RANK_W'(i % cdse_pkg::RANKS_PER_SUIT);
         deck_model[i].suit  = cdse_pkg::SUIT_W'((i / cdse_pkg::RANKS_PER_SUIT) % 4);
      end
   endfunction

   // apply one command to the deck copy and return its result
   function automatic card_outcome_type predict_command(
         input logic [cdse_pkg::CMD_W-1:0]  cmd,
         input logic [cdse_pkg::RAND_W-1:0] rnd,
         input logic [cdse_pkg::SLOT_W-1:0] slot);
      card_outcome_type         res;
      int unsigned              pos;
      int unsigned              pick;
      cdse_pkg::deck_entry_type held;
      bit                       found;
      res   = '0;
      found = 1'b0;
      case (cmd)
         cdse_pkg::CMD_INIT: begin
            load_ordered_deck();
         end
         cdse_pkg::CMD_SHUFFLE: begin
            pos = shuffle_pos_model;
            if (pos >= DECK || pos == 0) pos = DECK - 1;
            pick = rnd % (pos + 1);
            held             = deck_model[pos];
            deck_model[pos]  = deck_model[pick];
            deck_model[pick] = held;
            if (pos == 1) begin
               res.done          = 1'b1;
               shuffle_pos_model = cdse_pkg::SLOT_W'(DECK - 1);
            end else begin
               shuffle_pos_model = cdse_pkg::SLOT_W'(pos - 1);
            end
         end
         cdse_pkg::CMD_DRAW: begin
            for (int s = 0; s < DECK; s++) begin
               if (!found && !deck_model[s].empty) begin
                  res.rank            = deck_model[s].rank;
                  res.suit            = deck_model[s].suit;
                  res.valid           = 1'b1;
                  deck_model[s].empty = 1'b1;
                  found               = 1'b1;
               end
            end
         end
         default: begin
            // out-of-range slots are ignored
            if (slot < DECK) deck_model[slot].empty = 1'b1;
         end
      endcase
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random word with some weight on the edges
   function automatic logic [cdse_pkg::RAND_W-1:0] pick_random_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom();
      if (r < 87) return '0;
      if (r < 94) return '1;
      return cdse_pkg::RAND_W'($urandom_range(0, 63));
   endfunction

   // drive one command beat, wait for acceptance, record its expectation
   task automatic send_beat(input logic [cdse_pkg::CMD_W-1:0]  cmd,
                            input logic [cdse_pkg::RAND_W-1:0] rnd,
                            input logic [cdse_pkg::SLOT_W-1:0] slot);
      int unsigned gap;
      gap = idle_enable ? pick_gap() : 0;
      @(negedge clock);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.random_word <= rnd;
      req_bus.slot_index  <= slot;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      last_outcome = predict_command(cmd, rnd, slot);
      pending_outcomes.push_back(last_outcome);
      beats_sent++;
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_outcomes.size() == 0);
   endtask

   // result ready: random stalls plus an explicit long hold-off
   initial begin : result_ready_driver
      int unsigned stall;
      stall         = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (idle_enable) stall = pick_gap();
         end
      end
   end

   // compare every result beat with the oldest expectation
   initial begin : result_checker
      card_outcome_type want;
      card_outcome_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.rank  = rsp_bus.card_rank;
            got.suit  = rsp_bus.card_suit;
            got.valid = rsp_bus.card_valid;
            got.done  = rsp_bus.shuffle_done;
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result beat: rank %0d suit %0d valid %0b done %0b",
                           got.rank, got.suit, got.valid, got.done);
            end else begin
               want = pending_outcomes.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch at %0t: exp r%0d s%0d v%0b d%0b, got r%0d s%0d v%0b d%0b",
                              $realtime, want.rank, want.suit, want.valid, want.done,
                              got.rank, got.suit, got.valid, got.done);
               end
            end
         end
      end
   end

   // edges of the fields and each special case
   task automatic test_directed();
      idle_enable = 1'b1;
      send_beat(cdse_pkg::CMD_DRAW, '1, '1);              // lowest card from reset deck
      send_beat(cdse_pkg::CMD_DISCARD, '0, 6'd1);
      send_beat(cdse_pkg::CMD_DRAW, '0, '0);              // skips the discarded slot
      send_beat(cdse_pkg::CMD_DISCARD, '1, 6'd0);         // already empty
      send_beat(cdse_pkg::CMD_DISCARD, '0, 6'd52);        // out of range
      send_beat(cdse_pkg::CMD_DISCARD, '0, 6'd63);        // out of range
      send_beat(cdse_pkg::CMD_DISCARD, '0, 6'd51);
      send_beat(cdse_pkg::CMD_SHUFFLE, '0, '0);           // empty marks travel with the swap
      send_beat(cdse_pkg::CMD_SHUFFLE, '1, '1);
      send_beat(cdse_pkg::CMD_SHUFFLE, 32'd50, 6'd5);
      send_beat(cdse_pkg::CMD_SHUFFLE, 32'h8000_0000, '0);
      send_beat(cdse_pkg::CMD_SHUFFLE, 32'h5555_5555, 6'd42);
      send_beat(cdse_pkg::CMD_SHUFFLE, 32'hAAAA_AAAA, 6'd21);
      send_beat(cdse_pkg::CMD_DRAW, '0, '0);
      send_beat(cdse_pkg::CMD_INIT, '1, '1);
      send_beat(cdse_pkg::CMD_DRAW, '0, '0);
      send_beat(cdse_pkg::CMD_DISCARD, '0, 6'd42);
      send_beat(cdse_pkg::CMD_DISCARD, '0, 6'd21);
      send_beat(cdse_pkg::CMD_DRAW, '0, '0);
      send_beat(cdse_pkg::CMD_DRAW, '0, '0);
      send_beat(cdse_pkg::CMD_INIT, '0, '0);
   endtask

   // receiver holds off while draws keep coming, deck runs dry
   task automatic test_backpressure();
      idle_enable = 1'b0;
      send_beat(cdse_pkg::CMD_INIT, $urandom(), 6'($urandom_range(0, 63)));
      rsp_hold_cycles = LONG_HOLD;
      repeat (DECK + 4)
         send_beat(cdse_pkg::CMD_DRAW, $urandom(), 6'($urandom_range(0, 63)));
   endtask

   // shuffle passes followed by play, with some noise
   task automatic test_random_games();
      int unsigned r;
      while (beats_sent < ITEM_GOAL) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) != 0)
            send_beat(cdse_pkg::CMD_INIT, $urandom(), 6'($urandom_range(0, 63)));
         // mostly complete passes, sometimes a partial one
         if ($urandom_range(0, 2) != 0) begin
            do send_beat(cdse_pkg::CMD_SHUFFLE, pick_random_word(),
                         6'($urandom_range(0, 63)));
            while (!last_outcome.done);
         end else begin
            repeat ($urandom_range(0, 15))
               send_beat(cdse_pkg::CMD_SHUFFLE, pick_random_word(),
                         6'($urandom_range(0, 63)));
         end
         repeat ($urandom_range(20, 70)) begin
            r = $urandom_range(0, 99);
            if (r < 68)
               send_beat(cdse_pkg::CMD_DRAW, $urandom(), 6'($urandom_range(0, 63)));
            else if (r < 88)
               send_beat(cdse_pkg::CMD_DISCARD, $urandom(),
                         ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, DECK - 1))
                                                     : 6'($urandom_range(DECK, 63)));
            else if (r < 94)
               send_beat(cdse_pkg::CMD_SHUFFLE, pick_random_word(),
                         6'($urandom_range(0, 63)));
            else
               send_beat(cdse_pkg::CMD_INIT, $urandom(), 6'($urandom_range(0, 63)));
         end
      end
   endtask

   // sequence of tests
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = cdse_pkg::CMD_INIT;
      req_bus.random_word = '0;
      req_bus.slot_index  = '0;
      rsp_hold_cycles     = 0;
      idle_enable         = 1'b1;
      beats_sent          = 0;
      mismatch_count      = 0;
      load_ordered_deck();
      shuffle_pos_model   = cdse_pkg::SLOT_W'(DECK - 1);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_for_drain();
      test_backpressure();
      wait_for_drain();
      test_random_games();
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("PASS card_deck_shuffle_draw_engine_unit");
      else
         $display("FAIL card_deck_shuffle_draw_engine_unit");
      $finish;
   end

endmodule
